/* sv/dwo_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwo_pkg
// Shared types and constants of the detuned wavetable oscillator.
// ----------------------------------------------------------------------------
package dwo_pkg;

    localparam int MAX_VOICES      = 8;
    localparam int VOICE_W         = $clog2(MAX_VOICES);
    localparam int TABLE_ADDR_BITS = 10;
    localparam int TABLE_DEPTH     = 1 << TABLE_ADDR_BITS;
    localparam int PHASE_W         = 32;
    localparam int SAMPLE_W        = 16;
    localparam int DETUNE_BITS     = 10;
    localparam int FACTOR_ONE      = 1 << DETUNE_BITS;
    localparam int FACTOR_W        = 12;
    localparam int COUNT_W         = 4;
    localparam int DETUNE_W        = 4;
    localparam int SHIFT_W         = 2;
    localparam int SUM_W           = SAMPLE_W + VOICE_W;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 16;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_VOICE_COUNT    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DETUNE_STEP    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE_MASK = 2'd2;

    // item operations
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    // request to the phase step multiplier
    typedef struct packed {
        logic [PHASE_W-1:0]  base;
        logic [DETUNE_W-1:0] detune;
        logic [VOICE_W-1:0]  voice;
        logic [VOICE_W-1:0]  half;
        logic                single;
    } mul_req_t;

    // output attenuation by voice count
    function automatic logic [SHIFT_W-1:0] atten_shift(input logic [VOICE_W-1:0] vm1);
        logic [SHIFT_W-1:0] sh;
        case (vm1)
            3'd0:    sh = 2'd0;
            3'd1:    sh = 2'd1;
            3'd2:    sh = 2'd2;
            3'd3:    sh = 2'd2;
            default: sh = 2'd3;
        endcase
        return sh;
    endfunction

endpackage

/* sv/dwo_step_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwo_step_mul
// Shared phase step unit: forms a voice's Q10 detune factor and multiplies
// the scaled increment by it unless single, one voice per cycle, registered.
// ----------------------------------------------------------------------------
module dwo_step_mul
    import dwo_pkg::*;
(
    input  logic               clk,
    input  mul_req_t           req,
    output logic [PHASE_W-1:0] step
);

    logic signed [VOICE_W+1:0]  dev;
    logic signed [VOICE_W+1:0]  detune_s;
    logic signed [9:0]          offset;
    logic signed [FACTOR_W:0]   factor;
    logic [PHASE_W+FACTOR_W-1:0] full;
    logic [PHASE_W-1:0]         step_next;
    logic [PHASE_W-1:0]         step_reg;

    // factor = detune * (voice - half) + 1.0
    always_comb
    begin
        dev       = $signed({2'b00, req.voice}) - $signed({2'b00, req.half});
        detune_s  = $signed({1'b0, req.detune});
        offset    = 10'(detune_s) * 10'(dev);
        factor    = (FACTOR_W+1)'(FACTOR_ONE) + (FACTOR_W+1)'(offset);
        full      = req.base * factor[FACTOR_W-1:0];
        step_next = req.single ? req.base : full[PHASE_W-1:0];
    end

    // product register
    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
    end

    assign step = step_reg;

endmodule

/* sv/detuned_wavetable_oscillator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detuned_wavetable_oscillator_top
// Unison wavetable voice: up to eight phase accumulators read a shared
// table, masked samples are summed and attenuated into one output sample.
//
//   channel  signals                                                  direction
//   in       in_valid/in_ready, op, phase_step, table_index, table_value  sink
//   out      out_valid/out_ready, sample                              source
//   cfg      cfg_valid/cfg_ready, cfg_index, cfg_data                 sink
//
// A sample transfer steps through RUN, one voice at a time (N active voices,
// 1 in single-voice mode) through the shared read port and step multiplier,
// then DRAIN, then FINISH, which registers the output sample; the input
// takes a new item only in IDLE, and a table write leaves it ready.
// Reset clears phases, config and control; table contents stay undefined.
// A result waiting on out_ready holds the next sample in its last step.
// ----------------------------------------------------------------------------
module detuned_wavetable_oscillator_top
    import dwo_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          op,
    input  logic signed [PHASE_W-1:0]     phase_step,
    input  logic [TABLE_ADDR_BITS-1:0]    table_index,
    input  logic signed [SAMPLE_W-1:0]    table_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_W-1:0]    sample,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RUN    = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t                      state_reg, state_next;
    logic [COUNT_W-1:0]          voice_count_reg;
    logic [DETUNE_W-1:0]         detune_reg;
    logic [SAMPLE_W-1:0]         amp_mask_reg;
    logic [PHASE_W-1:0]          phase_reg [MAX_VOICES];
    logic [SAMPLE_W-1:0]         wave_table [TABLE_DEPTH];
    logic [SAMPLE_W-1:0]         rdata_reg;
    logic [TABLE_ADDR_BITS-1:0]  rd_addr;

    logic [PHASE_W-1:0]          base_reg, base_next;
    logic                        single_reg, single_next;
    logic [VOICE_W-1:0]          last_reg, last_next;
    logic [SHIFT_W-1:0]          shift_reg, shift_next;
    logic [VOICE_W-1:0]          idx_reg, idx_next;
    logic                        b_valid_reg, b_valid_next;
    logic [VOICE_W-1:0]          b_idx_reg, b_idx_next;
    logic signed [SUM_W-1:0]     sum_reg, sum_next;
    logic                        out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]         sample_reg, sample_next;

    logic                        in_xfer;
    logic                        cfg_xfer;
    logic                        single_mode;
    logic signed [SAMPLE_W-1:0]  masked;
    logic signed [SUM_W-1:0]     shifted;
    logic [COUNT_W-1:0]          vc_data;
    mul_req_t                    mul_req;
    logic [PHASE_W-1:0]          step;

    assign in_ready    = (state_reg == ST_IDLE);
    assign in_xfer     = in_valid && in_ready;
    assign cfg_ready   = 1'b1;
    assign cfg_xfer    = cfg_valid && cfg_ready;
    assign single_mode = (voice_count_reg == COUNT_W'(1)) || (detune_reg == '0);
    assign vc_data     = cfg_data[COUNT_W-1:0];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voice_count_reg <= COUNT_W'(1);
            detune_reg      <= '0;
            amp_mask_reg    <= '1;
        end
        else if (cfg_xfer)
        begin
            case (cfg_index)
                REG_VOICE_COUNT:
                begin
                    if (vc_data != '0 && vc_data <= COUNT_W'(MAX_VOICES))
                        voice_count_reg <= vc_data;
                end
                REG_DETUNE_STEP:    detune_reg   <= cfg_data[DETUNE_W-1:0];
                REG_AMPLITUDE_MASK: amp_mask_reg <= cfg_data[SAMPLE_W-1:0];
                default:            ;
            endcase
        end
    end

    // wave table: written on a write transfer, read one voice per cycle
    assign rd_addr = phase_reg[idx_reg][PHASE_W-1 -: TABLE_ADDR_BITS];

    always_ff @(posedge clk)
    begin
        if (in_xfer && op == OP_WRITE)
            wave_table[table_index] <= table_value;
        rdata_reg <= wave_table[rd_addr];
    end

    // shared step multiplier
    always_comb
    begin
        mul_req.base   = base_reg;
        mul_req.detune = detune_reg;
        mul_req.voice  = idx_reg;
        mul_req.half   = voice_count_reg[VOICE_W:1];
        mul_req.single = single_reg;
    end

    dwo_step_mul u_step_mul (
        .clk  (clk),
        .req  (mul_req),
        .step (step)
    );

    // phase accumulators, updated in the cycle after each voice issues
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_VOICES; i++)
                phase_reg[i] <= '0;
        end
        else if (b_valid_reg)
        begin
            phase_reg[b_idx_reg] <= phase_reg[b_idx_reg] + step;
        end
    end

    assign masked  = $signed(rdata_reg & amp_mask_reg);
    assign shifted = sum_reg >>> shift_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        single_next    = single_reg;
        last_next      = last_reg;
        shift_next     = shift_reg;
        idx_next       = idx_reg;
        b_valid_next   = 1'b0;
        b_idx_next     = idx_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        sample_next    = sample_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        // accumulate the voice read in the previous cycle
        if (b_valid_reg)
            sum_next = sum_reg + SUM_W'(masked);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && op == OP_SAMPLE)
                begin
                    single_next = single_mode;
                    base_next   = single_mode ? phase_step
                                              : PHASE_W'(phase_step >>> DETUNE_BITS);
                    last_next   = single_mode ? '0
                                              : VOICE_W'(voice_count_reg - COUNT_W'(1));
                    shift_next  = single_mode ? '0
                                              : atten_shift(VOICE_W'(voice_count_reg
                                                                     - COUNT_W'(1)));
                    idx_next    = '0;
                    sum_next    = '0;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN:
            begin
                b_valid_next = 1'b1;
                if (idx_reg == last_reg)
                    state_next = ST_DRAIN;
                else
                    idx_next = idx_reg + VOICE_W'(1);
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    sample_next    = shifted[SAMPLE_W-1:0];
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        base_reg   <= base_next;
        single_reg <= single_next;
        last_reg   <= last_next;
        shift_reg  <= shift_next;
        b_idx_reg  <= b_idx_next;
        sum_reg    <= sum_next;
        sample_reg <= sample_next;
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

endmodule

/* sv/dwo_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwo_checker
// Port-level checks of the oscillator top level, attached by bind.
// ----------------------------------------------------------------------------
module dwo_checker
    import dwo_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       op,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic signed [SAMPLE_W-1:0] sample,
    input logic                       cfg_ready
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample))
        else $error("result changed while stalled");

    // a sample transfer keeps the input closed while voices run
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && op == OP_SAMPLE |=> !in_ready)
        else $error("input ready during sample computation");

    // no result appears right after a transfer
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared too early");

    // a table write transfer leaves the input open
    a_write_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && op == OP_WRITE |=> in_ready)
        else $error("table write stalled input");

    // configuration is always taken
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind detuned_wavetable_oscillator_top dwo_checker u_dwo_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample    (sample),
    .cfg_ready (cfg_ready)
);

/* tb/sv/dwo_sample_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwo_sample_checker
// Watches the input, config and output channels of the oscillator. Keeps its
// own phases, wave table and registers, predicts every output sample and
// compares each output transfer in order against the oldest prediction.
// ----------------------------------------------------------------------------
module dwo_sample_checker
    import dwo_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic                       op,
    input  logic signed [PHASE_W-1:0]  phase_step,
    input  logic [TABLE_ADDR_BITS-1:0] table_index,
    input  logic signed [SAMPLE_W-1:0] table_value,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    output int                         mismatch_count,
    output int                         samples_owed
);

    localparam int REPORT_LIMIT = 10;

    // predictor state
    logic [PHASE_W-1:0]         acc_phase [MAX_VOICES];
    logic [SAMPLE_W-1:0]        wave [TABLE_DEPTH];
    logic [COUNT_W-1:0]         voices;
    logic [DETUNE_W-1:0]        detune;
    logic [SAMPLE_W-1:0]        amp_mask;
    logic signed [SAMPLE_W-1:0] expected_samples [$];
    logic signed [SAMPLE_W-1:0] want;
    int                         errs = 0;

    // table read at the top address bits of a phase, then masked
    function automatic logic signed [SAMPLE_W-1:0] masked_tap(input logic [PHASE_W-1:0] ph);
        return wave[ph[PHASE_W-1 -: TABLE_ADDR_BITS]] & amp_mask;
    endfunction

    // one sample item: read all active voices, advance their phases
    function automatic logic signed [SAMPLE_W-1:0] render_sample(
        input logic signed [PHASE_W-1:0] step
    );
        logic signed [PHASE_W-1:0] coarse;
        int acc;
        int half;
        int factor;
        int sh;
        coarse = step >>> DETUNE_BITS;
        // single voice: phase 0 only, plain increment
        if (voices == 4'd1 || detune == '0)
        begin
            acc = int'(masked_tap(acc_phase[0]));
            acc_phase[0] = acc_phase[0] + step;
            return acc[SAMPLE_W-1:0];
        end
        // unison: Q10 factor centered on half the voice count
        acc  = 0;
        half = int'(voices) >> 1;
        for (int v = 0; v < int'(voices); v++)
        begin
            factor = int'(detune) * (v - half) + FACTOR_ONE;
            acc += int'(masked_tap(acc_phase[v]));
            acc_phase[v] = acc_phase[v] + coarse * factor;
        end
        case (voices)
            4'd2:       sh = 1;
            4'd3, 4'd4: sh = 2;
            default:    sh = 3;
        endcase
        acc = acc >>> sh;
        return acc[SAMPLE_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int v = 0; v < MAX_VOICES; v++)
                acc_phase[v] = '0;
            voices   = 4'd1;
            detune   = '0;
            amp_mask = '1;
            expected_samples.delete();
            mismatch_count <= errs;
            samples_owed   <= 0;
        end
        else
        begin
            // register write transfer; bad voice counts keep the old value
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_VOICE_COUNT:
                        if (cfg_data[COUNT_W-1:0] != '0 && cfg_data[COUNT_W-1:0] <= MAX_VOICES)
                            voices = cfg_data[COUNT_W-1:0];
                    REG_DETUNE_STEP:    detune   = cfg_data[DETUNE_W-1:0];
                    REG_AMPLITUDE_MASK: amp_mask = cfg_data[SAMPLE_W-1:0];
                    default: ;
                endcase
            end
            // output transfer against the oldest prediction
            if (out_valid && out_ready)
            begin
                if (expected_samples.size() == 0)
                begin
                    if (errs < REPORT_LIMIT)
                        $display("%0t: sample %0d arrived with nothing predicted",
                                 $time, sample);
                    errs++;
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (sample !== want)
                    begin
                        if (errs < REPORT_LIMIT)
                            $display("%0t: sample mismatch: expected %0d, got %0d",
                                     $time, want, sample);
                        errs++;
                    end
                end
            end
            // input transfer: table write or sample prediction
            if (in_valid && in_ready)
            begin
                if (op == OP_WRITE)
                    wave[table_index] = table_value;
                else
                    expected_samples.push_back(render_sample(phase_step));
            end
            mismatch_count <= errs;
            samples_owed   <= expected_samples.size();
        end
    end

endmodule

/* tb/sv/tb_detuned_wavetable_oscillator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_detuned_wavetable_oscillator_top
// Fills the wave table, runs directed samples over extreme increments and
// register settings, then random phases of table writes and samples under
// varied voice count, detune and mask, with random stalls on both channels.
// Checking is done by dwo_sample_checker.
// ----------------------------------------------------------------------------
module tb_detuned_wavetable_oscillator_top;
    import dwo_pkg::*;

    localparam int     CLK_PERIOD    = 10;
    localparam int     RESET_CYCLES  = 9;
    localparam int     SETTLE_CYCLES = 16;
    localparam int     LONG_HOLD     = 300;
    localparam int     RANDOM_PHASES = 12;
    localparam int     PHASE_ITEMS   = 34;
    localparam longint TIMEOUT_NS    = 64'd8_000_000;

    // index past the register list, must be ignored
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    logic                       clk         = 1'b0;
    logic                       rst_n       = 1'b0;
    logic                       in_valid    = 1'b0;
    logic                       in_ready;
    logic                       op          = OP_SAMPLE;
    logic signed [PHASE_W-1:0]  phase_step  = '0;
    logic [TABLE_ADDR_BITS-1:0] table_index = '0;
    logic signed [SAMPLE_W-1:0] table_value = '0;
    logic                       out_valid;
    logic                       out_ready   = 1'b0;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       cfg_valid   = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_W-1:0]     cfg_index   = '0;
    logic [CFG_DATA_W-1:0]      cfg_data    = '0;
    int                         mismatch_count;
    int                         samples_owed;

    // pacing controls
    int   gap_pct    = 0;
    logic hold_req   = 1'b0;
    logic hold_done  = 1'b0;
    logic quiet_tail = 1'b0;
    int   stall_left = 0;
    int   span_left  = 0;
    int   stall_pct  = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    detuned_wavetable_oscillator_top dut (.*);

    dwo_sample_checker u_checker (.*);

    // random field values of the right width
    function automatic logic [TABLE_ADDR_BITS-1:0] rand_index();
        return TABLE_ADDR_BITS'($urandom);
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_value();
        return SAMPLE_W'($urandom);
    endfunction

    // output side: random stall bursts, calm spans, one long hold
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (quiet_tail)
            out_ready <= 1'b1;
        else if (hold_req && !hold_done)
        begin
            hold_done  <= 1'b1;
            stall_left <= LONG_HOLD;
            out_ready  <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else
        begin
            if (span_left == 0)
            begin
                span_left <= $urandom_range(40, 300);
                stall_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
            end
            else
                span_left <= span_left - 1;
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                stall_left <= $urandom_range(0, 13);
                out_ready  <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // one input transfer, with an optional gap in front of it
    task automatic send_item(input logic kind, input logic [PHASE_W-1:0] step,
                             input logic [TABLE_ADDR_BITS-1:0] idx,
                             input logic [SAMPLE_W-1:0] val);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= kind;
        phase_step  <= step;
        table_index <= idx;
        table_value <= val;
        do @(posedge clk); while (!in_ready);
    endtask

    // stop sending and wait until every predicted sample has come out
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (samples_owed != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one register transfer, valid left high for a following write
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // idle the block, then load all three registers
    task automatic retune(input int nv, input int dt, input logic [SAMPLE_W-1:0] mask,
                          input bit junk);
        logic [CFG_DATA_W-1:0] data;
        drain();
        data      = CFG_DATA_W'($urandom);
        data[3:0] = COUNT_W'(nv);
        write_reg(REG_VOICE_COUNT, data);
        data      = CFG_DATA_W'($urandom);
        data[3:0] = DETUNE_W'(dt);
        write_reg(REG_DETUNE_STEP, data);
        write_reg(REG_AMPLITUDE_MASK, mask);
        // voice counts of zero or above the maximum are dropped
        if (junk)
        begin
            data      = CFG_DATA_W'($urandom);
            data[3:0] = 4'd0;
            write_reg(REG_VOICE_COUNT, data);
            data[3:0] = COUNT_W'($urandom_range(MAX_VOICES + 1, 15));
            write_reg(REG_VOICE_COUNT, data);
            write_reg(REG_SPARE, CFG_DATA_W'($urandom));
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [PHASE_W-1:0]  step;
        logic [SAMPLE_W-1:0] val;
        logic [SAMPLE_W-1:0] mask;
        int                  roll;
        int                  nv;
        int                  dt;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // fill the whole table so every phase lands on a written entry
        gap_pct = 15;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            case (i)
                0:       val = 16'h8000;
                1:       val = 16'h7FFF;
                2:       val = 16'h0000;
                3:       val = 16'hFFFF;
                default: val = rand_value();
            endcase
            send_item(OP_WRITE, $urandom, i[TABLE_ADDR_BITS-1:0], val);
        end

        // single voice after reset: extreme increments and wrap of phase 0
        gap_pct = 0;
        send_item(OP_SAMPLE, 32'h0000_0000, rand_index(), rand_value());
        send_item(OP_SAMPLE, 32'h0040_0000, rand_index(), rand_value());
        send_item(OP_SAMPLE, 32'h7FFF_FFFF, rand_index(), rand_value());
        send_item(OP_SAMPLE, 32'h8000_0000, rand_index(), rand_value());
        send_item(OP_SAMPLE, 32'hFFFF_FFFF, rand_index(), rand_value());
        send_item(OP_SAMPLE, 32'h0000_0001, rand_index(), rand_value());
        send_item(OP_WRITE, $urandom, '0, 16'h7FFF);
        send_item(OP_SAMPLE, 32'h0000_0000, rand_index(), rand_value());

        // full unison, widest detune, sign-only mask
        retune(MAX_VOICES, 15, 16'h8000, 1'b0);
        send_item(OP_SAMPLE, 32'h8000_0000, rand_index(), rand_value());
        send_item(OP_SAMPLE, 32'h7FFF_FFFF, rand_index(), rand_value());
        send_item(OP_SAMPLE, 32'hFFFF_FFFF, rand_index(), rand_value());
        send_item(OP_SAMPLE, 32'h0000_0400, rand_index(), rand_value());

        // zero detune forces one voice; bad voice counts and spare index ignored
        retune(MAX_VOICES, 0, 16'h0000, 1'b1);
        send_item(OP_SAMPLE, 32'h0123_4567, rand_index(), rand_value());
        send_item(OP_SAMPLE, 32'hFEDC_BA98, rand_index(), rand_value());

        // two voices, smallest detune
        retune(2, 1, 16'h7FFF, 1'b0);
        send_item(OP_SAMPLE, 32'h0100_0000, rand_index(), rand_value());
        send_item(OP_SAMPLE, 32'hF000_0000, rand_index(), rand_value());
        send_item(OP_SAMPLE, 32'h0000_03FF, rand_index(), rand_value());

        // one voice with detune set stays single
        retune(1, 15, 16'hFFFF, 1'b0);
        send_item(OP_SAMPLE, 32'h1234_5678, rand_index(), rand_value());
        send_item(OP_SAMPLE, 32'h8765_4321, rand_index(), rand_value());

        // random phases
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    nv = MAX_VOICES;
                    dt = 15;
                end
                1:
                begin
                    nv = 1;
                    dt = $urandom_range(0, 15);
                end
                2:
                begin
                    nv = $urandom_range(2, MAX_VOICES);
                    dt = 0;
                end
                default:
                begin
                    nv = $urandom_range(1, MAX_VOICES);
                    dt = $urandom_range(1, 15);
                end
            endcase
            roll = $urandom_range(0, 9);
            case (roll)
                0, 1, 2, 3: mask = 16'hFFFF;
                4:          mask = 16'h8000;
                5:          mask = 16'h7FFF;
                6:          mask = 16'h0000;
                default:    mask = rand_value();
            endcase
            retune(nv, dt, mask, p % 3 == 1);
            gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            // long output hold while input keeps coming
            if (p == 3)
            begin
                hold_req <= 1'b1;
                gap_pct = 0;
            end
            // no idling on either side at the end
            if (p == RANDOM_PHASES - 1)
            begin
                quiet_tail <= 1'b1;
                gap_pct = 0;
            end
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 10)
                    send_item(OP_WRITE, $urandom, rand_index(), rand_value());
                else
                begin
                    if (roll < 45)
                        step = $urandom;
                    else if (roll < 75)
                    begin
                        step = $urandom_range(0, 32'h0100_0000);
                        if ($urandom_range(0, 1) == 1)
                            step = -step;
                    end
                    else if (roll < 88)
                        step = PHASE_W'($urandom_range(0, 15)) << (PHASE_W - TABLE_ADDR_BITS);
                    else
                    begin
                        case ($urandom_range(0, 5))
                            0:       step = 32'h0000_0000;
                            1:       step = 32'h0000_0001;
                            2:       step = 32'hFFFF_FFFF;
                            3:       step = 32'h7FFF_FFFF;
                            4:       step = 32'h8000_0000;
                            default: step = 32'h0000_0400;
                        endcase
                    end
                    send_item(OP_SAMPLE, step, rand_index(), rand_value());
                end
            end
        end

        drain();
        if (mismatch_count == 0)
            $display("tb_detuned_wavetable_oscillator_top: done, clean");
        else
            $display("tb_detuned_wavetable_oscillator_top: done, errors");
        $finish;
    end

    // run limit
    initial
    begin
        #(TIMEOUT_NS);
        $display("tb_detuned_wavetable_oscillator_top: done, errors");
        $finish;
    end

endmodule

/* filelist.f */
sv/dwo_pkg.sv
sv/dwo_step_mul.sv
sv/detuned_wavetable_oscillator_top.sv
sv/dwo_checker.sv
tb/sv/dwo_sample_checker.sv
tb/sv/tb_detuned_wavetable_oscillator_top.sv
